// File: rtl/lpce_pkg.sv
package lpce_pkg;

    localparam int VAL_W     = 32;
    localparam int FRAC_BITS = 24;
    localparam int L_W       = 30;
    localparam int E_W       = 34;
    localparam int P_W       = 33;
    localparam int CFG_IDX_W = 3;

    // Lane depth: exponent stage, one root stage per fraction bit, shift, map
    localparam int POW_LAT = FRAC_BITS + 3;

    localparam logic [P_W-1:0] P_ONE   = {1'b1, {(P_W-1){1'b0}}};
    localparam logic [E_W-1:0] E_LIMIT = E_W'(33) << FRAC_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LUM_LOW    = 3'd0,
        CFG_LUM_HIGH   = 3'd1,
        CFG_GAMMA_NORM = 3'd2,
        CFG_GAMMA_UP   = 3'd3,
        CFG_GAMMA_DOWN = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic valid;
        logic clamped;
        logic xzero;
        logic xone;
    } t_side;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bw;
        rem = v;
        res = '0;
        bw  = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bw) begin
                rem = rem - (res + bw);
                res = (res >> 1) + bw;
            end else begin
                res = res >> 1;
            end
            bw = bw >> 2;
        end
        return res;
    endfunction

    // 2^-(2^-j) in Q0.32
    function automatic logic [31:0] root_const(input int j);
        logic [63:0] r;
        r = isqrt64(64'h8000_0000_0000_0000);
        for (int i = 2; i <= j; i++) begin
            r = isqrt64({r[31:0], 32'b0});
        end
        return r[31:0];
    endfunction

endpackage

// File: rtl/lpce_in_if.sv
interface lpce_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] luminance;

    modport source (output valid, output luminance, input ready);
    modport sink   (input valid, input luminance, output ready);
endinterface

// File: rtl/lpce_out_if.sv
interface lpce_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] image_norm;
    logic [31:0] adapt_up_time;
    logic [31:0] adapt_down_time;
    logic        clamped;

    modport source (output valid, output image_norm, output adapt_up_time,
                    output adapt_down_time, output clamped, input ready);
    modport sink   (input valid, input image_norm, input adapt_up_time,
                    input adapt_down_time, input clamped, output ready);
endinterface

// File: rtl/luminance_power_curve_eval.sv
// Channel  Dir  Handshake     Payload
// i_in     in   valid/ready   luminance (Q16.16)
// o_out    out  valid/ready   image_norm, adapt_up_time, adapt_down_time (Q16.16), clamped
// i_cfg_*  in   write enable  index 0..4, 32-bit data
//
// One sample enters per cycle unless the output stalls. Stages: 1 range check,
// 32 divider stages (one quotient bit each), 5 normalize, 24 squaring stages,
// 1 log assemble, then per curve 1 exponent multiply, 24 root multiplies,
// 1 shift and 1 map stage that is the output register.
// Synchronous active-low reset clears the valid bits and loads register defaults.
// When the output is stalled the whole pipeline holds; nothing is lost or repeated.
module luminance_power_curve_eval #(
    parameter logic [31:0] NORM_AT_LOW  = 32'd5898,
    parameter logic [31:0] NORM_AT_HIGH = 32'd43090,
    parameter logic [31:0] UP_AT_LOW    = 32'd6554,
    parameter logic [31:0] UP_AT_HIGH   = 32'd1966080,
    parameter logic [31:0] DOWN_AT_LOW  = 32'd19660800,
    parameter logic [31:0] DOWN_AT_HIGH = 32'd32768
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lpce_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [31:0]                     i_cfg_data,
    lpce_in_if.sink                         i_in,
    lpce_out_if.source                      o_out
);

    localparam int PL = lpce_pkg::POW_LAT;

    logic [31:0] r_lum_low;
    logic [31:0] r_lum_high;
    logic [31:0] r_gamma_norm;
    logic [31:0] r_gamma_up;
    logic [31:0] r_gamma_down;

    // Register file; writes to unlisted indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lum_low    <= 32'd92;
            r_lum_high   <= 32'd524288000;
            r_gamma_norm <= 32'd117072755;
            r_gamma_up   <= 32'd214031642;
            r_gamma_down <= 32'd2931584;
        end else if (i_cfg_we) begin
            unique case (lpce_pkg::t_cfg_idx'(i_cfg_idx))
                lpce_pkg::CFG_LUM_LOW:    r_lum_low    <= i_cfg_data;
                lpce_pkg::CFG_LUM_HIGH:   r_lum_high   <= i_cfg_data;
                lpce_pkg::CFG_GAMMA_NORM: r_gamma_norm <= i_cfg_data;
                lpce_pkg::CFG_GAMMA_UP:   r_gamma_up   <= i_cfg_data;
                lpce_pkg::CFG_GAMMA_DOWN: r_gamma_down <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Global advance: move when the output slot is empty or being taken
    logic en;
    assign en          = !o_out.valid || o_out.ready;
    assign i_in.ready  = en;

    lpce_pkg::t_side div_side;
    logic [31:0]     div_xn;

    lpce_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_in.valid),
        .i_lum      (i_in.luminance),
        .i_lum_low  (r_lum_low),
        .i_lum_high (r_lum_high),
        .o_side     (div_side),
        .o_xn       (div_xn)
    );

    lpce_pkg::t_side             log_side;
    logic [lpce_pkg::L_W-1:0]    log_l;

    lpce_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (div_side),
        .i_xn    (div_xn),
        .o_side  (log_side),
        .o_l     (log_l)
    );

    logic [31:0] norm_val;
    logic [31:0] up_val;
    logic [31:0] down_val;

    lpce_pow #(.AT_LOW(NORM_AT_LOW), .AT_HIGH(NORM_AT_HIGH)) u_pow_norm (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_l     (log_l),
        .i_gamma (r_gamma_norm),
        .i_xzero (log_side.xzero),
        .i_xone  (log_side.xone),
        .o_value (norm_val)
    );

    lpce_pow #(.AT_LOW(UP_AT_LOW), .AT_HIGH(UP_AT_HIGH)) u_pow_up (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_l     (log_l),
        .i_gamma (r_gamma_up),
        .i_xzero (log_side.xzero),
        .i_xone  (log_side.xone),
        .o_value (up_val)
    );

    lpce_pow #(.AT_LOW(DOWN_AT_LOW), .AT_HIGH(DOWN_AT_HIGH)) u_pow_down (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_l     (log_l),
        .i_gamma (r_gamma_down),
        .i_xzero (log_side.xzero),
        .i_xone  (log_side.xone),
        .o_value (down_val)
    );

    // Carry valid and clamp flag alongside the curve lanes
    logic r_vld [PL];
    logic r_clp [PL];

    for (genvar s = 0; s < PL; s++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
                r_clp[s] <= 1'b0;
            end else if (en) begin
                r_vld[s] <= (s == 0) ? log_side.valid   : r_vld[(s == 0) ? 0 : s-1];
                r_clp[s] <= (s == 0) ? log_side.clamped : r_clp[(s == 0) ? 0 : s-1];
            end
        end
    end

    assign o_out.valid           = r_vld[PL-1];
    assign o_out.clamped         = r_clp[PL-1];
    assign o_out.image_norm      = norm_val;
    assign o_out.adapt_up_time   = up_val;
    assign o_out.adapt_down_time = down_val;

endmodule

// File: rtl/lpce_div.sv
module lpce_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [31:0]         i_lum,
    input  logic [31:0]         i_lum_low,
    input  logic [31:0]         i_lum_high,
    output lpce_pkg::t_side     o_side,
    output logic [31:0]         o_xn
);

    localparam int NSTG = 32;

    lpce_pkg::t_side r_side [NSTG+1];
    logic [31:0]     r_rem  [NSTG+1];
    logic [31:0]     r_quo  [NSTG+1];

    logic [31:0] span;
    assign span = i_lum_high - i_lum_low;

    // Range check and offset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side[0] <= '0;
        end else if (i_en) begin
            r_side[0].valid   <= i_valid;
            r_side[0].clamped <= (i_lum < i_lum_low) || (i_lum > i_lum_high);
            r_side[0].xzero   <= i_lum <= i_lum_low;
            r_side[0].xone    <= (i_lum > i_lum_low) && (i_lum >= i_lum_high);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_lum - i_lum_low;
            r_quo[0] <= '0;
        end
    end

    // One quotient bit per stage
    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic [32:0] dbl;
        logic        ge;
        logic [31:0] n_rem;

        always_comb begin
            dbl   = {r_rem[s], 1'b0};
            ge    = dbl >= {1'b0, span};
            n_rem = ge ? 32'(dbl - {1'b0, span}) : dbl[31:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[s+1] <= '0;
            end else if (i_en) begin
                r_side[s+1] <= r_side[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= n_rem;
                r_quo[s+1] <= {r_quo[s][30:0], ge};
            end
        end
    end

    assign o_side = r_side[NSTG];
    assign o_xn   = r_quo[NSTG];

endmodule

// File: rtl/lpce_log.sv
module lpce_log (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  lpce_pkg::t_side            i_side,
    input  logic [31:0]                i_xn,
    output lpce_pkg::t_side            o_side,
    output logic [lpce_pkg::L_W-1:0]   o_l
);

    localparam int NLZ = 5;
    localparam int NSQ = lpce_pkg::FRAC_BITS;
    localparam int NALL = NLZ + NSQ;

    lpce_pkg::t_side r_side [NALL+2];
    logic [31:0]     r_m    [NALL+1];
    logic [4:0]      r_lz   [NALL+1];
    logic [lpce_pkg::FRAC_BITS-1:0] r_frac [NALL+1];
    logic [lpce_pkg::L_W-1:0] r_l;

    assign r_side[0] = i_side;
    assign r_m[0]    = i_xn;
    assign r_lz[0]   = '0;
    assign r_frac[0] = '0;

    for (genvar s = 0; s <= NALL; s++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[s+1] <= '0;
            end else if (i_en) begin
                r_side[s+1] <= r_side[s];
            end
        end
    end

    // Leading-zero normalization, binary search
    for (genvar s = 0; s < NLZ; s++) begin : g_lz
        localparam int SH = 16 >> s;
        logic hit;
        assign hit = r_m[s][31 -: SH] == '0;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[s+1]    <= hit ? (r_m[s] << SH) : r_m[s];
                r_lz[s+1]   <= hit ? (r_lz[s] + 5'(SH)) : r_lz[s];
                r_frac[s+1] <= r_frac[s];
            end
        end
    end

    // One fraction bit per squaring
    for (genvar s = NLZ; s < NALL; s++) begin : g_sq
        logic [63:0] sq;
        logic [32:0] sc;
        assign sq = 64'(r_m[s]) * 64'(r_m[s]);
        assign sc = sq[63:31];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[s+1]    <= sc[32] ? sc[32:1] : sc[31:0];
                r_frac[s+1] <= {r_frac[s][lpce_pkg::FRAC_BITS-2:0], sc[32]};
                r_lz[s+1]   <= r_lz[s];
            end
        end
    end

    logic [5:0] ipart;
    assign ipart = 6'(r_lz[NALL]) + 6'd1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l <= {ipart, {lpce_pkg::FRAC_BITS{1'b0}}}
                 - {6'b0, r_frac[NALL]};
        end
    end

    assign o_side = r_side[NALL+1];
    assign o_l    = r_l;

endmodule

// File: rtl/lpce_pow.sv
module lpce_pow #(
    parameter logic [31:0] AT_LOW  = 32'd0,
    parameter logic [31:0] AT_HIGH = 32'd65536
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [lpce_pkg::L_W-1:0]   i_l,
    input  logic [31:0]                i_gamma,
    input  logic                       i_xzero,
    input  logic                       i_xone,
    output logic [31:0]                o_value
);

    localparam int NR  = lpce_pkg::FRAC_BITS;
    localparam int P_W = lpce_pkg::P_W;
    localparam int E_W = lpce_pkg::E_W;
    localparam bit RISING = AT_HIGH >= AT_LOW;
    localparam logic [31:0] SPAN = RISING ? (AT_HIGH - AT_LOW) : (AT_LOW - AT_HIGH);

    logic [P_W-1:0] r_p    [NR+1];
    logic [E_W-1:0] r_e    [NR+1];
    logic           r_one  [NR+1];
    logic           r_zero [NR+1];
    logic [P_W-1:0] r_pf;
    logic [31:0]    r_val;

    logic [61:0] eprod;
    assign eprod = 62'(i_l) * 62'(i_gamma);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e[0]    <= eprod[61:28];
            r_p[0]    <= lpce_pkg::P_ONE;
            r_one[0]  <= i_xone || (i_gamma == '0);
            r_zero[0] <= i_xzero;
        end
    end

    // One root factor per fraction bit of the exponent
    for (genvar j = 1; j <= NR; j++) begin : g_root
        localparam logic [31:0] ROOT = lpce_pkg::root_const(j);
        logic [64:0] prod;
        assign prod = 65'(r_p[j-1]) * 65'(ROOT);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[j]    <= r_e[j-1][NR-j] ? prod[64:32] : r_p[j-1];
                r_e[j]    <= r_e[j-1];
                r_one[j]  <= r_one[j-1];
                r_zero[j] <= r_zero[j-1];
            end
        end
    end

    logic [5:0] ishift;
    assign ishift = r_e[NR][NR+5:NR];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_one[NR]) begin
                r_pf <= lpce_pkg::P_ONE;
            end else if (r_zero[NR] || (r_e[NR] >= lpce_pkg::E_LIMIT)) begin
                r_pf <= '0;
            end else begin
                r_pf <= r_p[NR] >> ishift;
            end
        end
    end

    logic [64:0] mprod;
    logic [32:0] step;
    assign mprod = 65'(r_pf) * 65'(SPAN) + 65'(33'h0_8000_0000);
    assign step  = mprod[64:32];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= RISING ? 32'(AT_LOW + step[31:0]) : 32'(AT_LOW - step[31:0]);
        end
    end

    assign o_value = r_val;

endmodule

// File: test/lpce_curve_checker.sv
`timescale 1ns / 1ps

module lpce_curve_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    lpce_in_if          in_mon,
    lpce_out_if         out_mon,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked,
    output int          o_clamped
);

    localparam logic [31:0] NORM_LO = 32'd5898;
    localparam logic [31:0] NORM_HI = 32'd43090;
    localparam logic [31:0] UP_LO   = 32'd6554;
    localparam logic [31:0] UP_HI   = 32'd1966080;
    localparam logic [31:0] DOWN_LO = 32'd19660800;
    localparam logic [31:0] DOWN_HI = 32'd32768;
    localparam logic [32:0] UNITY   = 33'h1_0000_0000;

    typedef struct {
        logic [31:0] norm;
        logic [31:0] up;
        logic [31:0] down;
        logic        clamped;
    } t_curve_vals;

    t_curve_vals  curve_q[$];
    logic [63:0]  half_root[1:24];
    logic [31:0]  lo_reg, hi_reg, g_norm, g_up, g_down;

    // bit-by-bit integer square root
    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] acc;
        logic [127:0] trial;
        acc = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = (acc | (64'd1 << b)) * (acc | (64'd1 << b));
            if (trial <= {64'd0, v}) acc = acc | (64'd1 << b);
        end
        return acc;
    endfunction

    initial begin
        half_root[1] = root64(64'h8000_0000_0000_0000);
        for (int j = 2; j <= 24; j++) half_root[j] = root64(half_root[j-1] << 32);
    end

    function automatic logic [32:0] normalize(input logic [31:0] lum);
        if (lum <= lo_reg) return '0;
        if (lum >= hi_reg) return UNITY;
        return 33'((({32'd0, lum - lo_reg}) << 32) / {32'd0, hi_reg - lo_reg});
    endfunction

    function automatic logic [32:0] raise(input logic [32:0] xn, input logic [31:0] g);
        logic [63:0] m, p, e, lg;
        logic [23:0] fr;
        int msb;
        if (xn >= UNITY || g == 0) return UNITY;
        if (xn == 0) return '0;
        msb = 31;
        while (!xn[msb]) msb--;
        m = 64'(xn) << (31 - msb);
        fr = '0;
        for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 31;
            fr = fr << 1;
            if (m >= 64'(UNITY)) begin
                fr[0] = 1'b1;
                m = m >> 1;
            end
        end
        lg = (64'(32 - msb) << 24) - 64'(fr);
        e  = (lg * 64'(g)) >> 28;
        if (e >= (64'd33 << 24)) return '0;
        p = 64'(UNITY);
        for (int j = 1; j <= 24; j++)
            if (e[24-j]) p = (p * half_root[j]) >> 32;
        p = p >> e[63:24];
        return p[32:0];
    endfunction

    function automatic logic [31:0] place(input logic [32:0] p, input logic [31:0] lo,
                                          input logic [31:0] hi);
        logic [63:0] span, t;
        span = (hi >= lo) ? 64'(hi - lo) : 64'(lo - hi);
        t = (64'(p) * span + 64'h8000_0000) >> 32;
        return (hi >= lo) ? lo + t[31:0] : lo - t[31:0];
    endfunction

    function automatic t_curve_vals eval_curves(input logic [31:0] lum);
        t_curve_vals v;
        logic [32:0] xn;
        xn = normalize(lum);
        v.norm    = place(raise(xn, g_norm), NORM_LO, NORM_HI);
        v.up      = place(raise(xn, g_up), UP_LO, UP_HI);
        v.down    = place(raise(xn, g_down), DOWN_LO, DOWN_HI);
        v.clamped = (lum < lo_reg) || (lum > hi_reg);
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_curve_vals want;
        int bad;
        bad = 0;
        if (!i_rst_n) begin
            lo_reg <= 32'd92;
            hi_reg <= 32'd524288000;
            g_norm <= 32'd117072755;
            g_up   <= 32'd214031642;
            g_down <= 32'd2931584;
            curve_q.delete();
            o_errors  <= 0;
            o_pending <= 0;
            o_checked <= 0;
            o_clamped <= 0;
        end else begin
            if (i_cfg_we) begin
                case (lpce_pkg::t_cfg_idx'(i_cfg_idx))
                    lpce_pkg::CFG_LUM_LOW:    lo_reg <= i_cfg_data;
                    lpce_pkg::CFG_LUM_HIGH:   hi_reg <= i_cfg_data;
                    lpce_pkg::CFG_GAMMA_NORM: g_norm <= i_cfg_data;
                    lpce_pkg::CFG_GAMMA_UP:   g_up   <= i_cfg_data;
                    lpce_pkg::CFG_GAMMA_DOWN: g_down <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_mon.valid && in_mon.ready) curve_q.push_back(eval_curves(in_mon.luminance));
            if (out_mon.valid && out_mon.ready) begin
                if (curve_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    bad++;
                end else begin
                    want = curve_q.pop_front();
                    if (out_mon.image_norm !== want.norm) begin
                        $error("image_norm: expected %0d, got %0d", want.norm,
                               out_mon.image_norm);
                        bad++;
                    end
                    if (out_mon.adapt_up_time !== want.up) begin
                        $error("adapt_up_time: expected %0d, got %0d", want.up,
                               out_mon.adapt_up_time);
                        bad++;
                    end
                    if (out_mon.adapt_down_time !== want.down) begin
                        $error("adapt_down_time: expected %0d, got %0d", want.down,
                               out_mon.adapt_down_time);
                        bad++;
                    end
                    if (out_mon.clamped !== want.clamped) begin
                        $error("clamped: expected %0b, got %0b", want.clamped,
                               out_mon.clamped);
                        bad++;
                    end
                    o_checked <= o_checked + 1;
                    if (want.clamped) o_clamped <= o_clamped + 1;
                end
            end
            o_errors  <= o_errors + bad;
            o_pending <= curve_q.size();
        end
    end
endmodule

// File: test/tb_luminance_power_curve_eval.sv
`timescale 1ns / 1ps

module tb_luminance_power_curve_eval;

    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 120;   // pipeline is about 90 deep

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [31:0] cfg_data = '0;
    int          cycles = 0;
    int          errors, pending, checked, clamped_seen;
    int          stall_left = 0;
    int          phases = 0;
    logic [31:0] cur_lo, cur_hi;

    lpce_in_if  in_ch ();
    lpce_out_if out_ch ();

    luminance_power_curve_eval dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    lpce_curve_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .in_mon     (in_ch),
        .out_mon    (out_ch),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_checked  (checked),
        .o_clamped  (clamped_seen)
    );

    always #6 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Idle length: mostly short, now and then long; quiet windows with none at all
    function automatic int pick_gap();
        if (cycles[10]) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Hold ready low for random stretches to back-pressure the pipeline
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            out_ch.ready <= 1'b1;
            if (!cycles[11]) stall_left <= pick_gap();
        end
    end

    // Push one luminance transaction and wait for its acceptance
    task automatic push_lum(input logic [31:0] lum);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.luminance <= lum;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Drop valid and let every outstanding result come back
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input lpce_pkg::t_cfg_idx idx, input logic [31:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        if (idx == lpce_pkg::CFG_LUM_LOW) cur_lo = val;
        if (idx == lpce_pkg::CFG_LUM_HIGH) cur_hi = val;
    endtask

    task automatic set_all(input logic [31:0] lo, input logic [31:0] hi,
                           input logic [31:0] gn, input logic [31:0] gu,
                           input logic [31:0] gd);
        write_reg(lpce_pkg::CFG_LUM_LOW, lo);
        write_reg(lpce_pkg::CFG_LUM_HIGH, hi);
        write_reg(lpce_pkg::CFG_GAMMA_NORM, gn);
        write_reg(lpce_pkg::CFG_GAMMA_UP, gu);
        write_reg(lpce_pkg::CFG_GAMMA_DOWN, gd);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Edges of the luminance range, the endpoints themselves, full-scale extremes and fixed patterns
    task automatic edge_sweep();
        logic [31:0] span;
        span = cur_hi - cur_lo;
        push_lum(32'd0);
        push_lum(32'hFFFF_FFFF);
        push_lum(cur_lo);
        push_lum(cur_lo - 1);
        push_lum(cur_lo + 1);
        push_lum(cur_hi);
        push_lum(cur_hi - 1);
        push_lum(cur_hi + 1);
        push_lum(cur_lo + (span >> 1));
        push_lum(cur_lo + (span >> 8));
        push_lum(32'hAAAA_AAAA);
        push_lum(32'h5555_5555);
    endtask

    // Mostly in-range samples, some at edges, some anywhere
    task automatic random_run(input int n);
        logic [31:0] lum;
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 9);
            if (sel < 6 && cur_hi > cur_lo)
                lum = cur_lo + $urandom_range(0, cur_hi - cur_lo);
            else if (sel < 8)
                lum = (sel == 6 ? cur_lo : cur_hi) + $urandom_range(0, 6) - 3;
            else
                lum = $urandom;
            push_lum(lum);
        end
    endtask

    task automatic run_phase(input logic [31:0] lo, input logic [31:0] hi,
                             input logic [31:0] gn, input logic [31:0] gu,
                             input logic [31:0] gd, input int n);
        set_all(lo, hi, gn, gu, gd);
        edge_sweep();
        random_run(n);
        drain();
        phases++;
    endtask

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.luminance = '0;
        cur_lo = 32'd92;
        cur_hi = 32'd524288000;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults first, untouched
        edge_sweep();
        random_run(150);
        drain();
        phases++;

        // full range, exponents at their extremes (and one at unity)
        run_phase(32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd1, 120);
        run_phase(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'h1000_0000, 120);
        // narrow window, small exponents and one at its maximum
        run_phase(32'h0001_0000, 32'h0001_0010, 32'd1, 32'h0800_0000, 32'hFFFF_FFFF, 100);
        // reversed and equal endpoints
        run_phase(32'h0100_0000, 32'h0000_1000, 32'h1000_0000, 32'h2000_0000,
                  32'h0100_0000, 60);
        run_phase(32'h0040_0000, 32'h0040_0000, 32'h1000_0000, 32'h1000_0000,
                  32'h1000_0000, 60);
        // random settings
        for (int k = 0; k < 4; k++) begin
            logic [31:0] a, b;
            a = $urandom;
            b = $urandom;
            if (a > b) run_phase(b, a, $urandom, $urandom_range(0, 32'h3000_0000),
                                 $urandom, 100);
            else run_phase(a, b, $urandom_range(0, 32'h3000_0000), $urandom,
                           $urandom, 100);
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending != 0) $error("%0d results never arrived", pending);

        $display("checked %0d results (%0d clamped) over %0d register settings",
                 checked, clamped_seen, phases);
        $display("in %0d cycles with random gaps and output stalls", cycles);
        if (errors == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// File: filelist.f
rtl/lpce_pkg.sv
rtl/lpce_in_if.sv
rtl/lpce_out_if.sv
rtl/lpce_div.sv
rtl/lpce_log.sv
rtl/lpce_pow.sv
rtl/luminance_power_curve_eval.sv
test/lpce_curve_checker.sv
test/tb_luminance_power_curve_eval.sv
